/* rtl/core/ifs_chaos_game_point_generator_assert.svh */
// assertion macros for the chaos game point generator
`ifndef IFS_CHAOS_GAME_POINT_GENERATOR_ASSERT_SVH
`define IFS_CHAOS_GAME_POINT_GENERATOR_ASSERT_SVH

`ifndef SYNTH
`define IFSCG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IFSCG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IFSCG_ASSERT(label, clk, rst, prop, msg)
`define IFSCG_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/core/ifscg_pkg.sv */
package ifscg_pkg;

   localparam int unsigned WORDS_PER_MAP = 7;
   localparam int unsigned COEF_COLS     = 6;
   localparam int unsigned PROB_COL      = 6;
   localparam int unsigned COL_A         = 0;
   localparam int unsigned COL_B         = 1;
   localparam int unsigned COL_C         = 2;
   localparam int unsigned COL_D         = 3;
   localparam int unsigned COL_E         = 4;
   localparam int unsigned COL_F         = 5;
   localparam int unsigned COLOR_MAX     = 255;

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_PRECISION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRADIENT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PTS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_LEN = 2'd3;

   localparam logic [13:0] PRECISION_RST = 14'd6;
   localparam logic [8:0]  GRADIENT_RST  = 9'd1;
   localparam logic [19:0] MAX_PTS_RST   = 20'd100000;
   localparam logic [13:0] BATCH_LEN_RST = 14'd1000;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_STEP    = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CUM,
      ST_SEL,
      ST_MULX,
      ST_MULY,
      ST_SUM,
      ST_SCALE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [4:0]         coef_slot;
      logic signed [31:0] coef_value;
      logic [15:0]        random_fraction;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic clear_cur;
      logic capture;
      logic cum;
      logic sel;
      logic mul_x;
      logic mul_y;
      logic sum;
      logic scale;
      logic out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v[63:31] != {33{v[63]}}) begin
         r = v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // min(255, floor(mag * grad / 2^16))
   function automatic logic [7:0] channel(input logic [32:0] mag, input logic [8:0] grad);
      logic [32:0] prod;
      logic [7:0]  r;
      prod = 33'(mag[23:0]) * 33'(grad);
      if (grad == '0) begin
         r = '0;
      end else if (mag[32:24] != '0) begin
         r = 8'(COLOR_MAX);
      end else if (prod[32:24] != '0) begin
         r = 8'(COLOR_MAX);
      end else begin
         r = prod[23:16];
      end
      return r;
   endfunction

endpackage

/* rtl/core/ifs_chaos_game_point_generator.sv */
// step transaction: accepted in idle, then the cum, sel, mul_x, mul_y, sum, scale and out states run in
// order; out holds until the output register is free and then loads the result; no request is taken until idle
// load, restart and a step dropped at a full batch start are handled in idle; the step sequencer uses
// one 32x32 multiplier pair for the affine products (mul_x, mul_y) and for output scaling (scale)
// synchronous active-high reset: table, point and counters to zero, registers to defaults
`include "ifs_chaos_game_point_generator_assert.svh"

module ifs_chaos_game_point_generator #(
   parameter int unsigned NUM_MAPS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ifscg_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ifscg_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_we,
   input  logic [ifscg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ifscg_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [13:0] precision_ff;
   logic [8:0]  gradient_ff;
   logic [19:0] max_pts_ff;
   logic [13:0] batch_len_ff;

   ifscg_pkg::cmd_type    cmd;
   ifscg_pkg::status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         precision_ff <= ifscg_pkg::PRECISION_RST;
         gradient_ff  <= ifscg_pkg::GRADIENT_RST;
         max_pts_ff   <= ifscg_pkg::MAX_PTS_RST;
         batch_len_ff <= ifscg_pkg::BATCH_LEN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            ifscg_pkg::CSR_PRECISION: precision_ff <= csr_wdata[13:0];
            ifscg_pkg::CSR_GRADIENT:  gradient_ff  <= csr_wdata[8:0];
            ifscg_pkg::CSR_MAX_PTS:   max_pts_ff   <= csr_wdata[19:0];
            ifscg_pkg::CSR_BATCH_LEN: batch_len_ff <= csr_wdata[13:0];
         endcase
      end
   end

   ifscg_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_data.operation),
      .max_points   (max_pts_ff),
      .batch_length (batch_len_ff),
      .status       (status),
      .cmd          (cmd)
   );

   ifscg_dp #(
      .NUM_MAPS (NUM_MAPS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_data        (req_data),
      .precision_scale (precision_ff),
      .color_gradient  (gradient_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data)
   );

   `IFSCG_ASSERT(a_one_step_cmd, clock, reset, $onehot0({cmd.load, cmd.cum, cmd.sel, cmd.mul_x, cmd.mul_y, cmd.sum, cmd.scale, cmd.out}), "more than one datapath command active")
   `IFSCG_ASSERT(a_no_overwrite, clock, reset, cmd.out |-> (!rsp_valid || rsp_ready), "result overwritten before its transaction")
   `IFSCG_ASSERT(a_rsp_source, clock, reset, $rose(rsp_valid) |-> $past(cmd.out), "result valid without an output load")
   `IFSCG_ASSERT_NEXT(a_capture_seq, clock, reset, cmd.capture, cmd.cum && !req_ready, "step did not enter the sequencer")

endmodule

/* rtl/core/ifscg_ctrl.sv */
module ifscg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_op,
   input  logic [19:0]            max_points,
   input  logic [13:0]            batch_length,
   input  ifscg_pkg::status_type  status,
   output ifscg_pkg::cmd_type     cmd
);

   ifscg_pkg::state_type state_ff, state_in;
   logic [13:0] pos_ff, pos_in, pos_inc;
   logic [19:0] count_ff, count_in;
   logic        stop;

   assign stop    = (pos_ff == '0) && (count_ff >= max_points);
   assign pos_inc = pos_ff + 14'd1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ifscg_pkg::ST_IDLE: begin
            if (req_valid && (req_op == ifscg_pkg::OP_STEP) && !stop) begin
               state_in = ifscg_pkg::ST_CUM;
            end
         end
         ifscg_pkg::ST_CUM:   state_in = ifscg_pkg::ST_SEL;
         ifscg_pkg::ST_SEL:   state_in = ifscg_pkg::ST_MULX;
         ifscg_pkg::ST_MULX:  state_in = ifscg_pkg::ST_MULY;
         ifscg_pkg::ST_MULY:  state_in = ifscg_pkg::ST_SUM;
         ifscg_pkg::ST_SUM:   state_in = ifscg_pkg::ST_SCALE;
         ifscg_pkg::ST_SCALE: state_in = ifscg_pkg::ST_OUT;
         ifscg_pkg::ST_OUT: begin
            if (status.out_free) begin
               state_in = ifscg_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ifscg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_op)
                  ifscg_pkg::OP_LOAD: cmd.load = 1'b1;
                  ifscg_pkg::OP_STEP: begin
                     cmd.clear_cur = (pos_ff == '0);
                     cmd.capture   = !stop;
                  end
                  ifscg_pkg::OP_RESTART: cmd.clear_cur = 1'b1;
                  default: ;
               endcase
            end
         end
         ifscg_pkg::ST_CUM:   cmd.cum   = 1'b1;
         ifscg_pkg::ST_SEL:   cmd.sel   = 1'b1;
         ifscg_pkg::ST_MULX:  cmd.mul_x = 1'b1;
         ifscg_pkg::ST_MULY:  cmd.mul_y = 1'b1;
         ifscg_pkg::ST_SUM:   cmd.sum   = 1'b1;
         ifscg_pkg::ST_SCALE: cmd.scale = 1'b1;
         ifscg_pkg::ST_OUT:   cmd.out   = status.out_free;
      endcase
   end

   // batch position and point count
   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      priority if ((state_ff == ifscg_pkg::ST_IDLE) && req_valid &&
                   (req_op == ifscg_pkg::OP_RESTART)) begin
         pos_in   = '0;
         count_in = '0;
      end else if ((state_ff == ifscg_pkg::ST_OUT) && status.out_free) begin
         pos_in   = (pos_inc >= batch_length) ? '0 : pos_inc;
         count_in = (count_ff != '1) ? count_ff + 20'd1 : count_ff;
      end else begin
         pos_in   = pos_ff;
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ifscg_pkg::ST_IDLE;
         pos_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/core/ifscg_dp.sv */
module ifscg_dp #(
   parameter int unsigned NUM_MAPS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ifscg_pkg::cmd_type     cmd,
   output ifscg_pkg::status_type  status,
   input  ifscg_pkg::req_type     req_data,
   input  logic [13:0]            precision_scale,
   input  logic [8:0]             color_gradient,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ifscg_pkg::rsp_type     rsp_data
);

   localparam int unsigned MAP_W = $clog2(NUM_MAPS);
   localparam int unsigned CUM_W = 32 + $clog2(NUM_MAPS);

   logic signed [31:0] coef_ff [NUM_MAPS][ifscg_pkg::COEF_COLS];
   logic signed [31:0] prob_ff [NUM_MAPS];

   logic signed [CUM_W-1:0] cum_in [NUM_MAPS];
   logic signed [CUM_W-1:0] cum_ff [NUM_MAPS];
   logic signed [CUM_W-1:0] p_ext;
   logic [15:0]             p_ff;
   logic [MAP_W-1:0]        choice_ff, choice_in;
   logic                    found;

   logic signed [31:0] cur_x_ff, cur_y_ff, cur_x_in, cur_y_in;
   logic signed [31:0] scale_ext;
   logic signed [31:0] mul0_a, mul0_b, mul1_a, mul1_b;
   logic signed [63:0] prod0, prod1;
   logic signed [63:0] acc0_ff, acc1_ff, acc2_ff, acc3_ff;
   logic signed [64:0] sum_x, sum_y;
   logic signed [63:0] aff_x, aff_y;

   logic signed [32:0] wide_x, wide_y, wide_s;
   logic [32:0]        mag_x_ff, mag_y_ff, mag_s_ff;

   logic               rsp_valid_ff;
   ifscg_pkg::rsp_type rsp_data_ff;

   // coefficient table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < NUM_MAPS; m++) begin
            prob_ff[m] <= '0;
            for (int c = 0; c < ifscg_pkg::COEF_COLS; c++) begin
               coef_ff[m][c] <= '0;
            end
         end
      end else if (cmd.load) begin
         for (int m = 0; m < NUM_MAPS; m++) begin
            if (32'(req_data.coef_slot) ==
                32'(m * ifscg_pkg::WORDS_PER_MAP + ifscg_pkg::PROB_COL)) begin
               prob_ff[m] <= req_data.coef_value;
            end
            for (int c = 0; c < ifscg_pkg::COEF_COLS; c++) begin
               if (32'(req_data.coef_slot) == 32'(m * ifscg_pkg::WORDS_PER_MAP + c)) begin
                  coef_ff[m][c] <= req_data.coef_value;
               end
            end
         end
      end
   end

   // cumulative probabilities and map choice
   always_comb begin
      cum_in[0] = CUM_W'(prob_ff[0]);
      for (int i = 1; i < NUM_MAPS; i++) begin
         cum_in[i] = cum_in[i-1] + CUM_W'(prob_ff[i]);
      end
   end

   assign p_ext = $signed(CUM_W'(p_ff));

   always_comb begin
      choice_in = '0;
      found     = 1'b0;
      for (int i = 0; i < NUM_MAPS - 1; i++) begin
         if (!found && (p_ext > cum_ff[i]) && (p_ext <= cum_ff[i+1])) begin
            choice_in = MAP_W'(i + 1);
            found     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         p_ff <= req_data.random_fraction;
      end
      if (cmd.cum) begin
         for (int i = 0; i < NUM_MAPS; i++) begin
            cum_ff[i] <= cum_in[i];
         end
      end
      if (cmd.sel) begin
         choice_ff <= choice_in;
      end
   end

   // shared multiplier pair
   assign scale_ext = $signed(32'(precision_scale));

   always_comb begin
      priority if (cmd.mul_x) begin
         mul0_a = coef_ff[choice_ff][ifscg_pkg::COL_A];
         mul0_b = cur_x_ff;
         mul1_a = coef_ff[choice_ff][ifscg_pkg::COL_C];
         mul1_b = cur_x_ff;
      end else if (cmd.mul_y) begin
         mul0_a = coef_ff[choice_ff][ifscg_pkg::COL_B];
         mul0_b = cur_y_ff;
         mul1_a = coef_ff[choice_ff][ifscg_pkg::COL_D];
         mul1_b = cur_y_ff;
      end else begin
         mul0_a = cur_x_ff;
         mul0_b = scale_ext;
         mul1_a = cur_y_ff;
         mul1_b = scale_ext;
      end
   end

   assign prod0 = mul0_a * mul0_b;
   assign prod1 = mul1_a * mul1_b;

   always_ff @(posedge clock) begin
      if (cmd.mul_x || cmd.scale) begin
         acc0_ff <= prod0;
         acc1_ff <= prod1;
      end
      if (cmd.mul_y) begin
         acc2_ff <= prod0;
         acc3_ff <= prod1;
      end
   end

   // floor of the product sum, then offset and saturate
   assign sum_x = 65'(acc0_ff) + 65'(acc2_ff);
   assign sum_y = 65'(acc1_ff) + 65'(acc3_ff);
   assign aff_x = 64'($signed(sum_x[64:16])) + 64'(coef_ff[choice_ff][ifscg_pkg::COL_E]);
   assign aff_y = 64'($signed(sum_y[64:16])) + 64'(coef_ff[choice_ff][ifscg_pkg::COL_F]);

   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      priority if (cmd.clear_cur) begin
         cur_x_in = '0;
         cur_y_in = '0;
      end else if (cmd.sum) begin
         cur_x_in = ifscg_pkg::sat32(aff_x);
         cur_y_in = ifscg_pkg::sat32(aff_y);
      end else begin
         cur_x_in = cur_x_ff;
         cur_y_in = cur_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
      end else begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
      end
   end

   // magnitudes for the color channels
   assign wide_x = 33'(cur_x_ff);
   assign wide_y = 33'(cur_y_ff);
   assign wide_s = wide_x + wide_y;

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         mag_x_ff <= wide_x[32] ? 33'(-wide_x) : 33'(wide_x);
         mag_y_ff <= wide_y[32] ? 33'(-wide_y) : 33'(wide_y);
         mag_s_ff <= wide_s[32] ? 33'(-wide_s) : 33'(wide_s);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out) begin
         rsp_data_ff.point_x <= ifscg_pkg::sat32(acc0_ff);
         rsp_data_ff.point_y <= ifscg_pkg::sat32(acc1_ff);
         rsp_data_ff.red     <= ifscg_pkg::channel(mag_x_ff, color_gradient);
         rsp_data_ff.green   <= ifscg_pkg::channel(mag_y_ff, color_gradient);
         rsp_data_ff.blue    <= ifscg_pkg::channel(mag_s_ff, color_gradient);
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule
